// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_decode, cartridge_bank_mapper and cbm_checker; depends on nothing.
package cbm_pkg;

    // CPU bus and physical ROM widths
    localparam int CPU_ADDR_W  = 16;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_BANK_W  = 7;
    localparam int RAM_BANK_W  = 2;
    localparam int BANK_BYTES  = 16384;
    localparam int BANK_BITS   = $clog2(BANK_BYTES);
    localparam int WINDOW_BITS = BANK_BITS + 1;    // two banks visible to the CPU

    // Access kinds
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_READ_BYTE = 2'd1;
    localparam logic [1:0] KIND_READ_WORD = 2'd2;

    // Top byte source codes
    localparam logic [1:0] SRC_BYTE   = 2'd0;
    localparam logic [1:0] SRC_HIGH   = 2'd1;
    localparam logic [1:0] SRC_FORCED = 2'd2;

    // Mapper types
    localparam logic MAPPER_PLAIN = 1'b0;
    localparam logic MAPPER_MBC1  = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_TYPE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_SIZE_CODE = 2'd2;

    // Control register write regions
    localparam logic [CPU_ADDR_W-1:0] RAM_ENABLE_END = 16'h2000;
    localparam logic [CPU_ADDR_W-1:0] ROM_BANK_END   = 16'h4000;
    localparam logic [CPU_ADDR_W-1:0] RAM_BANK_END   = 16'h6000;
    localparam logic [3:0]            RAM_ENABLE_KEY = 4'hA;

    // Size code thresholds
    localparam logic [3:0] ROM_UPPER_CODE  = 4'd5;
    localparam logic [2:0] RAM_BANKED_CODE = 3'd3;

    // Last address of the plain 32 KB image
    localparam logic [CPU_ADDR_W-1:0] PLAIN_LAST_ADDR = 16'h7FFF;

    typedef struct packed {
        logic                  ram_enable;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
    } cbm_state_t;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] low_address;
        logic [ROM_ADDR_W-1:0] high_address;
        logic [1:0]            top_source;
        logic                  ram_enabled;
    } cbm_result_t;

endpackage

// ===== rtl/core/cbm_decode.sv =====
// Access decode: control register writes and ROM address mapping for one access.
// Purely combinational; depends on cbm_pkg.
module cbm_decode (
    input  logic [1:0]                        kind,
    input  logic [cbm_pkg::CPU_ADDR_W-1:0]    cpu_address,
    input  logic [7:0]                        write_value,
    input  logic                              mapper_type,
    input  logic [3:0]                        rom_size_code,
    input  logic [2:0]                        ram_size_code,
    input  cbm_pkg::cbm_state_t               state,
    output cbm_pkg::cbm_state_t               state_next,
    output cbm_pkg::cbm_result_t              result,
    output logic                              has_result
);

    logic [cbm_pkg::WINDOW_BITS-1:0] masked;
    logic [4:0]                      bank_mask;
    logic [4:0]                      bank_low;
    logic [cbm_pkg::ROM_BANK_W-1:0]  bank_merged;
    logic [cbm_pkg::ROM_BANK_W-1:0]  bank_value;
    logic                            upper_used;
    logic                            ram_bank_writable;
    logic [cbm_pkg::ROM_ADDR_W-1:0]  plain_low;
    logic [cbm_pkg::ROM_ADDR_W-1:0]  plain_high;
    logic                            plain_forced;
    logic [cbm_pkg::ROM_ADDR_W-1:0]  mbc_low;
    logic [cbm_pkg::ROM_ADDR_W-1:0]  mbc_high;
    logic                            mbc_forced;

    assign masked = cpu_address[cbm_pkg::WINDOW_BITS-1:0];

    // Bank mask keeps bits 0..min(code,4)
    always_comb
    begin
        case (rom_size_code)
            4'd0:    bank_mask = 5'h01;
            4'd1:    bank_mask = 5'h03;
            4'd2:    bank_mask = 5'h07;
            4'd3:    bank_mask = 5'h0F;
            default: bank_mask = 5'h1F;
        endcase
    end

    assign upper_used  = (rom_size_code >= cbm_pkg::ROM_UPPER_CODE);
    assign bank_low    = write_value[4:0] & bank_mask;
    assign bank_merged = {(upper_used ? state.ram_bank : 2'b00), bank_low};
    // zero check looks at 5 bits of the raw value
    assign bank_value  = (write_value[4:0] == 5'd0) ? bank_merged + 7'd1 : bank_merged;
    assign ram_bank_writable = upper_used || (ram_size_code >= cbm_pkg::RAM_BANKED_CODE);

    // Plain 32 KB image
    assign plain_low    = {{(cbm_pkg::ROM_ADDR_W-cbm_pkg::WINDOW_BITS){1'b0}}, masked};
    assign plain_high   = {{(cbm_pkg::ROM_ADDR_W-cbm_pkg::WINDOW_BITS){1'b0}},
                           masked + {{(cbm_pkg::WINDOW_BITS-1){1'b0}}, 1'b1}};
    assign plain_forced = (cpu_address == cbm_pkg::PLAIN_LAST_ADDR);

    // Banked: upper window goes through rom_bank
    assign mbc_low    = masked[cbm_pkg::BANK_BITS]
                      ? {state.rom_bank, masked[cbm_pkg::BANK_BITS-1:0]}
                      : plain_low;
    assign mbc_high   = mbc_low + {{(cbm_pkg::ROM_ADDR_W-1){1'b0}}, 1'b1};
    assign mbc_forced = (masked[cbm_pkg::BANK_BITS-1:0] == {cbm_pkg::BANK_BITS{1'b1}});

    always_comb
    begin
        state_next = state;
        result     = '0;
        has_result = 1'b0;
        result.ram_enabled = state.ram_enable;
        case (kind)
            cbm_pkg::KIND_WRITE:
            begin
                if (mapper_type == cbm_pkg::MAPPER_MBC1)
                begin
                    if (cpu_address < cbm_pkg::RAM_ENABLE_END)
                    begin
                        state_next.ram_enable = (write_value[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                    end
                    else if (cpu_address < cbm_pkg::ROM_BANK_END)
                    begin
                        state_next.rom_bank = bank_value;
                    end
                    else if (cpu_address < cbm_pkg::RAM_BANK_END)
                    begin
                        if (ram_bank_writable)
                        begin
                            state_next.ram_bank = write_value[1:0];
                        end
                    end
                end
            end
            cbm_pkg::KIND_READ_BYTE, cbm_pkg::KIND_READ_WORD:
            begin
                has_result = 1'b1;
                if (mapper_type == cbm_pkg::MAPPER_PLAIN)
                begin
                    result.low_address = plain_low;
                end
                else
                begin
                    result.low_address = mbc_low;
                end
                if (kind == cbm_pkg::KIND_READ_WORD)
                begin
                    if (mapper_type == cbm_pkg::MAPPER_PLAIN ? plain_forced : mbc_forced)
                    begin
                        result.top_source = cbm_pkg::SRC_FORCED;
                    end
                    else
                    begin
                        result.top_source   = cbm_pkg::SRC_HIGH;
                        result.high_address = (mapper_type == cbm_pkg::MAPPER_PLAIN)
                                            ? plain_high : mbc_high;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: handshakes, mapper registers, result register.
// Depends on cbm_pkg and cbm_decode.
//
// Cartridge bank mapper, plain 32 KB ROM or MBC1 banked. CPU accesses come in on the
// in_valid/in_ready channel: byte writes update the mapper registers (RAM enable, ROM
// bank, RAM bank) in MBC1 mode only and give no result; byte and word reads each give
// one result with the physical ROM offsets of the low and top byte, and for word reads
// whose top byte falls past a bank edge (the image end for plain ROM) top_source marks
// it as forced. Kind 3 is dropped. Throughput is one access per cycle while no read
// waits on a stalled output. Decode and the mapper register update happen in the input
// register. A stalled output holds a read there and all accesses behind it; writes
// ahead of it keep flowing, and a new access is taken in the same cycle the held one
// moves on. Mapper registers are updated in access order, so every read sees all
// earlier writes. The configuration port (mapper_type, rom_size_code, ram_size_code at
// indexes 0, 1, 2) is always ready and must be written only while no access is in
// flight; other indexes are ignored.
module cartridge_bank_mapper (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
    // CPU accesses
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [cbm_pkg::CPU_ADDR_W-1:0]    cpu_address,
    input  logic [7:0]                        write_value,
    // results
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cbm_pkg::ROM_ADDR_W-1:0]    low_address,
    output logic [cbm_pkg::ROM_ADDR_W-1:0]    high_address,
    output logic [1:0]                        top_source,
    output logic                              ram_enabled
);

    // configuration
    logic                               mapper_type_reg;
    logic [3:0]                         rom_size_code_reg;
    logic [2:0]                         ram_size_code_reg;

    // mapper state
    cbm_pkg::cbm_state_t                state_reg;
    cbm_pkg::cbm_state_t                state_next;

    // input register
    logic                               s1_valid_reg;
    logic [1:0]                         s1_kind_reg;
    logic [cbm_pkg::CPU_ADDR_W-1:0]     s1_address_reg;
    logic [7:0]                         s1_value_reg;

    // result register
    logic                               out_valid_reg;
    cbm_pkg::cbm_result_t               result_reg;
    cbm_pkg::cbm_result_t               result_next;

    logic                               s1_has_result;
    logic                               s1_advance;
    logic                               in_transfer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_type_reg   <= cbm_pkg::MAPPER_PLAIN;
            rom_size_code_reg <= '0;
            ram_size_code_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cbm_pkg::CFG_MAPPER_TYPE:   mapper_type_reg   <= cfg_data[0];
                cbm_pkg::CFG_ROM_SIZE_CODE: rom_size_code_reg <= cfg_data[3:0];
                cbm_pkg::CFG_RAM_SIZE_CODE: ram_size_code_reg <= cfg_data[2:0];
                default:                    ;
            endcase
        end
    end

    cbm_decode u_decode (
        .kind          (s1_kind_reg),
        .cpu_address   (s1_address_reg),
        .write_value   (s1_value_reg),
        .mapper_type   (mapper_type_reg),
        .rom_size_code (rom_size_code_reg),
        .ram_size_code (ram_size_code_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (result_next),
        .has_result    (s1_has_result)
    );

    // An access with no result always drains; a read waits for room in the result reg.
    assign s1_advance  = s1_valid_reg && (!s1_has_result || !out_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_transfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_transfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            // mapper registers change when the write leaves the input register
            if (s1_advance)
            begin
                state_reg <= state_next;
            end

            if (s1_advance && s1_has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            s1_kind_reg    <= kind;
            s1_address_reg <= cpu_address;
            s1_value_reg   <= write_value;
        end
        if (s1_advance && s1_has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign low_address  = result_reg.low_address;
    assign high_address = result_reg.high_address;
    assign top_source   = result_reg.top_source;
    assign ram_enabled  = result_reg.ram_enabled;

endmodule

// ===== rtl/core/cbm_checker.sv =====
// Port-level checks for cartridge_bank_mapper, attached with a bind.
// Depends on cbm_pkg and the top level's port list.
module cbm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [1:0]                        kind,
    input logic [cbm_pkg::CPU_ADDR_W-1:0]    cpu_address,
    input logic [7:0]                        write_value,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [cbm_pkg::ROM_ADDR_W-1:0]    low_address,
    input logic [cbm_pkg::ROM_ADDR_W-1:0]    high_address,
    input logic [1:0]                        top_source,
    input logic                              ram_enabled
);

    // a waiting access keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(cpu_address)
            && $stable(write_value))
        else $error("access changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(low_address)
            && $stable(high_address) && $stable(top_source) && $stable(ram_enabled))
        else $error("result changed while stalled");

    // top offset is only meaningful when the top byte comes from ROM
    a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && top_source != cbm_pkg::SRC_HIGH |-> high_address == '0)
        else $error("high_address set without a ROM top byte");

    // the top byte follows the low byte within the bank
    a_high_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && top_source == cbm_pkg::SRC_HIGH |->
            high_address[cbm_pkg::BANK_BITS-1:0]
                == low_address[cbm_pkg::BANK_BITS-1:0] + 14'd1)
        else $error("top byte offset not adjacent to low byte");

    // forced top byte only at the last byte of a bank
    a_forced_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && top_source == cbm_pkg::SRC_FORCED |->
            low_address[cbm_pkg::BANK_BITS-1:0] == {cbm_pkg::BANK_BITS{1'b1}})
        else $error("top byte forced away from a bank edge");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
